### rtl/tank_pump_controller_assert.svh
// Assertion macros for the tank pump controller.
// Included by the top level; no other dependencies.
`ifndef TANK_PUMP_CONTROLLER_ASSERT_SVH
`define TANK_PUMP_CONTROLLER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TPC_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tank pump controller check failed");

// Next-cycle implication, checked outside reset.
`define TPC_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tank pump controller check failed");

`endif

### rtl/tpc_pkg.sv
// Shared types, constants and the per-sensor evaluation for the tank pump controller.
// No dependencies.
package tpc_pkg;

    localparam int LEVEL_W    = 10;
    localparam int TICK_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [LEVEL_W-1:0] FULL_LEVEL = 10'd1000;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STOP_PERCENT         = 3'd0,
        CFG_START_PERCENT        = 3'd1,
        CFG_FORCED_START_PERCENT = 3'd2,
        CFG_MAX_RUN_TICKS        = 3'd3,
        CFG_PAUSE_TICKS          = 3'd4,
        CFG_SONAR_ENABLE         = 3'd5,
        CFG_ANALOG_ENABLE        = 3'd6
    } t_cfg_idx;

    // One input beat as held in the input register.
    typedef struct packed {
        logic [LEVEL_W-1:0] sonar_level;
        logic [LEVEL_W-1:0] analog_level;
        logic               force_switch_changed;
        logic               force_switch_closed;
        logic               remote_force_toggle;
        logic               auto_switch_closed;
    } t_in_beat;

    // Outcome of one sensor for one tick.
    typedef struct packed {
        logic latch;     // next hysteresis latch
        logic level_ok;  // level high enough to pump and in range
        logic high;      // above forced-start level
    } t_sensor;

    function automatic t_sensor sensor_eval(
        input logic               en,
        input logic [LEVEL_W-1:0] lvl,
        input logic               latch,
        input logic [LEVEL_W-1:0] stop_lvl,
        input logic [LEVEL_W-1:0] start_lvl,
        input logic [LEVEL_W-1:0] forced_lvl
    );
        t_sensor res;
        res = '0;
        if (en) begin
            if (lvl < stop_lvl) begin
                res.latch = 1'b0;
            end else if (lvl > start_lvl) begin
                res.latch = 1'b1;
            end else begin
                res.latch = latch;
            end
            res.level_ok = (lvl >= stop_lvl) && (lvl <= FULL_LEVEL);
            res.high     = lvl > forced_lvl;
        end
        return res;
    endfunction

endpackage

### rtl/tank_pump_controller.sv
// Tank pump controller top level: input register, tick evaluation, result register.
// Depends on tpc_pkg and tank_pump_controller_assert.svh.
//
// Holding-tank pump relay controller. Each input beat is one tick: two tank
// levels in tenths of a percent and the force, remote-toggle and auto switch
// states. Per tick the block updates a hysteresis latch for each enabled
// sensor, the forced-on mode and a safety timer, and returns one result beat
// (relay_on, cooling_pause, high_level_override). The pump may run in forced
// mode or, in auto mode, while an enabled sensor with an in-range level has
// its latch set. After max_run_ticks of continuous running the relay drops
// and a cooling pause of pause_ticks follows, unless a level above
// forced_start_percent keeps the pump on. Tick counters are TIMER_BITS wide
// and saturate. Throughput is one beat per clock while the receiver does not
// stall. An accepted beat lands in the input register, then the evaluation
// logic fills the result register, where the receiver can take it. While a
// result waits, the input register still takes one more beat, then the
// input stalls until the receiver takes the result. Configuration writes
// take effect at the next clock edge and should be issued while no beat is
// in flight.
`include "tank_pump_controller_assert.svh"

module tank_pump_controller #(
    parameter int TIMER_BITS = 17
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration write port
    input  logic                           i_cfg_we,
    input  logic [tpc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tpc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input channel
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [tpc_pkg::LEVEL_W-1:0]    i_sonar_level,
    input  logic [tpc_pkg::LEVEL_W-1:0]    i_analog_level,
    input  logic                           i_force_switch_changed,
    input  logic                           i_force_switch_closed,
    input  logic                           i_remote_force_toggle,
    input  logic                           i_auto_switch_closed,
    // result channel
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic                           o_relay_on,
    output logic                           o_cooling_pause,
    output logic                           o_high_level_override
);
    import tpc_pkg::*;

    // Compare width covering both the tick counters and the 16-bit limits.
    localparam int CMP_W = (TIMER_BITS > TICK_W) ? TIMER_BITS : TICK_W;
    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [LEVEL_W-1:0] r_stop_percent;
    logic [LEVEL_W-1:0] r_start_percent;
    logic [LEVEL_W-1:0] r_forced_start_percent;
    logic [TICK_W-1:0]  r_max_run_ticks;
    logic [TICK_W-1:0]  r_pause_ticks;
    logic               r_sonar_enable;
    logic               r_analog_enable;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stop_percent         <= 10'd250;
            r_start_percent        <= 10'd500;
            r_forced_start_percent <= 10'd800;
            r_max_run_ticks        <= 16'd300;
            r_pause_ticks          <= 16'd300;
            r_sonar_enable         <= 1'b1;
            r_analog_enable        <= 1'b1;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_STOP_PERCENT:         r_stop_percent <= i_cfg_data[LEVEL_W-1:0];
                CFG_START_PERCENT:        r_start_percent <= i_cfg_data[LEVEL_W-1:0];
                CFG_FORCED_START_PERCENT: r_forced_start_percent <= i_cfg_data[LEVEL_W-1:0];
                CFG_MAX_RUN_TICKS:        r_max_run_ticks <= i_cfg_data[TICK_W-1:0];
                CFG_PAUSE_TICKS:          r_pause_ticks <= i_cfg_data[TICK_W-1:0];
                CFG_SONAR_ENABLE:         r_sonar_enable <= i_cfg_data[0];
                CFG_ANALOG_ENABLE:        r_analog_enable <= i_cfg_data[0];
                default: ;  // writes beyond the register list are dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake: input register feeds the result register
    // ------------------------------------------------------------------
    logic     r_in_valid;
    t_in_beat r_in;
    logic     r_out_valid;
    logic     r_relay_on;
    logic     r_cooling_pause;
    logic     r_high_level_override;
    logic     advance;    // input register may move into the result register
    logic     take_in;    // input beat accepted this cycle
    logic     step;       // a tick is evaluated and committed this cycle

    assign advance = !r_out_valid || !i_stall;
    assign o_stall = r_in_valid && !advance;
    assign take_in = i_valid && !o_stall;
    assign step    = r_in_valid && advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (take_in) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // Hold the payload while the beat waits.
    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_in.sonar_level          <= i_sonar_level;
            r_in.analog_level         <= i_analog_level;
            r_in.force_switch_changed <= i_force_switch_changed;
            r_in.force_switch_closed  <= i_force_switch_closed;
            r_in.remote_force_toggle  <= i_remote_force_toggle;
            r_in.auto_switch_closed   <= i_auto_switch_closed;
        end
    end

    // ------------------------------------------------------------------
    // Controller state
    // ------------------------------------------------------------------
    logic                  r_sonar_latch,  n_sonar_latch;
    logic                  r_analog_latch, n_analog_latch;
    logic                  r_forced_mode,  n_forced_mode;
    logic                  r_run_active,   n_run_active;
    logic [TIMER_BITS-1:0] r_run_elapsed,  n_run_elapsed;
    logic                  r_pause_active, n_pause_active;
    logic [TIMER_BITS-1:0] r_pause_elapsed, n_pause_elapsed;
    logic                  n_relay_on;
    logic                  n_cooling_pause;
    logic                  n_high_level_override;

    t_sensor               sonar_res;
    t_sensor               analog_res;
    logic [TIMER_BITS-1:0] run_inc;
    logic [TIMER_BITS-1:0] pause_inc;
    logic [TIMER_BITS-1:0] run_now;
    logic                  pump;
    logic                  any_ok;
    logic                  over_run;
    logic                  over_pause;

    always_comb begin
        // Switch change first, then the remote toggle.
        n_forced_mode = r_in.force_switch_changed ? r_in.force_switch_closed : r_forced_mode;
        if (r_in.remote_force_toggle) begin
            n_forced_mode = !n_forced_mode;
        end

        // Active timers advance one tick, saturating.
        run_inc   = (r_run_elapsed == TIMER_MAX) ? r_run_elapsed
                                                 : r_run_elapsed + TIMER_BITS'(1);
        pause_inc = (r_pause_elapsed == TIMER_MAX) ? r_pause_elapsed
                                                   : r_pause_elapsed + TIMER_BITS'(1);
        if (!r_run_active) begin
            run_inc = r_run_elapsed;
        end
        if (!r_pause_active) begin
            pause_inc = r_pause_elapsed;
        end

        sonar_res  = sensor_eval(r_sonar_enable, r_in.sonar_level, r_sonar_latch,
                                 r_stop_percent, r_start_percent, r_forced_start_percent);
        analog_res = sensor_eval(r_analog_enable, r_in.analog_level, r_analog_latch,
                                 r_stop_percent, r_start_percent, r_forced_start_percent);
        n_sonar_latch  = sonar_res.latch;
        n_analog_latch = analog_res.latch;

        // Pump request.
        any_ok = sonar_res.level_ok || analog_res.level_ok;
        pump   = n_forced_mode
              || (r_in.auto_switch_closed && sonar_res.level_ok && n_sonar_latch)
              || (r_in.auto_switch_closed && analog_res.level_ok && n_analog_latch);
        pump   = pump && any_ok && (n_forced_mode || r_in.auto_switch_closed);

        // A fresh run starts at zero; a running one keeps its advanced count.
        run_now    = r_run_active ? run_inc : '0;
        over_run   = CMP_W'(run_now) > CMP_W'(r_max_run_ticks);
        over_pause = CMP_W'(pause_inc) > CMP_W'(r_pause_ticks);

        n_run_active          = 1'b0;
        n_run_elapsed         = '0;
        n_pause_active        = 1'b0;
        n_pause_elapsed       = '0;
        n_relay_on            = 1'b0;
        n_cooling_pause       = 1'b0;
        n_high_level_override = 1'b0;

        if (pump) begin
            n_run_active  = 1'b1;
            n_run_elapsed = run_now;
            if (sonar_res.high || analog_res.high) begin
                // High level: run past the timer and drop any pause.
                n_relay_on            = 1'b1;
                n_high_level_override = 1'b1;
            end else if (over_run) begin
                n_cooling_pause = 1'b1;
                if (!r_pause_active) begin
                    n_pause_active = 1'b1;
                end else if (over_pause) begin
                    // Pause done: clear both timers for a fresh run.
                    n_run_active  = 1'b0;
                    n_run_elapsed = '0;
                end else begin
                    n_pause_active  = 1'b1;
                    n_pause_elapsed = pause_inc;
                end
            end else begin
                n_relay_on      = 1'b1;
                n_pause_active  = r_pause_active;
                n_pause_elapsed = pause_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sonar_latch   <= 1'b0;
            r_analog_latch  <= 1'b0;
            r_forced_mode   <= 1'b0;
            r_run_active    <= 1'b0;
            r_run_elapsed   <= '0;
            r_pause_active  <= 1'b0;
            r_pause_elapsed <= '0;
        end else if (step) begin
            r_sonar_latch   <= n_sonar_latch;
            r_analog_latch  <= n_analog_latch;
            r_forced_mode   <= n_forced_mode;
            r_run_active    <= n_run_active;
            r_run_elapsed   <= n_run_elapsed;
            r_pause_active  <= n_pause_active;
            r_pause_elapsed <= n_pause_elapsed;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_relay_on            <= n_relay_on;
            r_cooling_pause       <= n_cooling_pause;
            r_high_level_override <= n_high_level_override;
        end
    end

    assign o_valid               = r_out_valid;
    assign o_relay_on            = r_relay_on;
    assign o_cooling_pause       = r_cooling_pause;
    assign o_high_level_override = r_high_level_override;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `TPC_ASSERT_IMP(a_run_idle_zero, i_clk, i_rst_n, !r_run_active, r_run_elapsed == '0)
    `TPC_ASSERT_IMP(a_pause_idle_zero, i_clk, i_rst_n, !r_pause_active, r_pause_elapsed == '0)
    `TPC_ASSERT_IMP(a_pause_needs_run, i_clk, i_rst_n, r_pause_active, r_run_active)
    `TPC_ASSERT_NXT(a_step_gives_beat, i_clk, i_rst_n, step, r_out_valid)

endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for tank_pump_controller: random valid/stall traffic on both
// channels, a tick-by-tick relay predictor and an in-order result scoreboard.
// Depends on tpc_pkg and the tank_pump_controller RTL.

module tb_top;

    localparam int TICK_BITS  = 17;

    // One result beat as the block reports it.
    typedef struct packed {
        logic relay_on;
        logic cooling_pause;
        logic high_override;
    } t_pump_out;

    // One full register setting for a phase of the run.
    typedef struct {
        logic [tpc_pkg::LEVEL_W-1:0] stop_lvl;
        logic [tpc_pkg::LEVEL_W-1:0] start_lvl;
        logic [tpc_pkg::LEVEL_W-1:0] forced_lvl;
        logic [tpc_pkg::TICK_W-1:0]  max_run;
        logic [tpc_pkg::TICK_W-1:0]  pause_len;
        bit                          sonar_en;
        bit                          analog_en;
    } t_pump_setting;

    // Relay predictor plus the queue of relay decisions still owed by the block.
    class relay_tracker;
        logic [tpc_pkg::LEVEL_W-1:0] stop_lvl, start_lvl, forced_lvl;
        logic [tpc_pkg::TICK_W-1:0]  max_run, pause_len;
        bit                          sonar_en, analog_en;
        bit                          sonar_hold, analog_hold, forced_on, running, pausing;
        logic [TICK_BITS-1:0]        run_ticks, pause_count;
        t_pump_out                   expected_q[$];
        int                          errors;

        function new();
            stop_lvl    = 10'd250;
            start_lvl   = 10'd500;
            forced_lvl  = 10'd800;
            max_run     = 16'd300;
            pause_len   = 16'd300;
            sonar_en    = 1'b1;
            analog_en   = 1'b1;
            sonar_hold  = 1'b0;
            analog_hold = 1'b0;
            forced_on   = 1'b0;
            running     = 1'b0;
            pausing     = 1'b0;
            run_ticks   = '0;
            pause_count = '0;
            errors      = 0;
        endfunction

        function void set_reg(tpc_pkg::t_cfg_idx idx, logic [tpc_pkg::CFG_DATA_W-1:0] val);
            case (idx)
                tpc_pkg::CFG_STOP_PERCENT:         stop_lvl   = val[tpc_pkg::LEVEL_W-1:0];
                tpc_pkg::CFG_START_PERCENT:        start_lvl  = val[tpc_pkg::LEVEL_W-1:0];
                tpc_pkg::CFG_FORCED_START_PERCENT: forced_lvl = val[tpc_pkg::LEVEL_W-1:0];
                tpc_pkg::CFG_MAX_RUN_TICKS:        max_run    = val;
                tpc_pkg::CFG_PAUSE_TICKS:          pause_len  = val;
                tpc_pkg::CFG_SONAR_ENABLE:         sonar_en   = val[0];
                tpc_pkg::CFG_ANALOG_ENABLE:        analog_en  = val[0];
                default: ;
            endcase
        endfunction

        // Advance a tick counter, holding at all ones.
        function logic [TICK_BITS-1:0] bump(logic [TICK_BITS-1:0] v);
            return (&v) ? v : v + 1'b1;
        endfunction

        // Update one sensor's hysteresis latch and report its level and high flags.
        function void sense(input bit en, input logic [tpc_pkg::LEVEL_W-1:0] lvl,
                            inout bit hold, output bit ok, output bit high);
            ok   = 1'b0;
            high = 1'b0;
            if (!en) begin
                hold = 1'b0;
                return;
            end
            if (lvl < stop_lvl)
                hold = 1'b0;
            else if (lvl > start_lvl)
                hold = 1'b1;
            ok   = (lvl >= stop_lvl) && (lvl <= tpc_pkg::FULL_LEVEL);
            high = lvl > forced_lvl;
        endfunction

        function void note_tick(tpc_pkg::t_in_beat b);
            bit        s_ok, s_high, a_ok, a_high, want;
            t_pump_out res;
            res = '0;
            if (b.force_switch_changed)
                forced_on = b.force_switch_closed;
            if (b.remote_force_toggle)
                forced_on = !forced_on;
            if (running)
                run_ticks = bump(run_ticks);
            if (pausing)
                pause_count = bump(pause_count);
            sense(sonar_en, b.sonar_level, sonar_hold, s_ok, s_high);
            sense(analog_en, b.analog_level, analog_hold, a_ok, a_high);
            want = forced_on || (b.auto_switch_closed &&
                                 ((s_ok && sonar_hold) || (a_ok && analog_hold)));
            if (!(s_ok || a_ok) || !(forced_on || b.auto_switch_closed))
                want = 1'b0;
            if (want) begin
                if (!running) begin
                    running   = 1'b1;
                    run_ticks = '0;
                end
                if (s_high || a_high) begin
                    // high level wins over the safety timer and ends any pause
                    pausing           = 1'b0;
                    pause_count       = '0;
                    res.relay_on      = 1'b1;
                    res.high_override = 1'b1;
                end else if (run_ticks > max_run) begin
                    if (!pausing) begin
                        pausing     = 1'b1;
                        pause_count = '0;
                    end else if (pause_count > pause_len) begin
                        running     = 1'b0;
                        run_ticks   = '0;
                        pausing     = 1'b0;
                        pause_count = '0;
                    end
                    res.cooling_pause = 1'b1;
                end else begin
                    res.relay_on = 1'b1;
                end
            end else begin
                running     = 1'b0;
                run_ticks   = '0;
                pausing     = 1'b0;
                pause_count = '0;
            end
            expected_q.push_back(res);
        endfunction

        function void compare_bit(string name, logic want, logic got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s expected %0b got %0b", $time, name, want, got);
            end
        endfunction

        function void check_relay(t_pump_out got);
            t_pump_out want;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: result beat with nothing expected, expected none got %b",
                         $time, got);
                return;
            end
            want = expected_q.pop_front();
            compare_bit("relay_on", want.relay_on, got.relay_on);
            compare_bit("cooling_pause", want.cooling_pause, got.cooling_pause);
            compare_bit("high_level_override", want.high_override, got.high_override);
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT signals; every input starts at a known value.
    // ------------------------------------------------------------------
    logic                           i_clk                  = 1'b0;
    logic                           i_rst_n                = 1'b0;
    logic                           i_cfg_we               = 1'b0;
    logic [tpc_pkg::CFG_IDX_W-1:0]  i_cfg_idx              = '0;
    logic [tpc_pkg::CFG_DATA_W-1:0] i_cfg_data             = '0;
    logic                           i_valid                = 1'b0;
    logic                           o_stall;
    logic [tpc_pkg::LEVEL_W-1:0]    i_sonar_level          = '0;
    logic [tpc_pkg::LEVEL_W-1:0]    i_analog_level         = '0;
    logic                           i_force_switch_changed = 1'b0;
    logic                           i_force_switch_closed  = 1'b0;
    logic                           i_remote_force_toggle  = 1'b0;
    logic                           i_auto_switch_closed   = 1'b0;
    logic                           o_valid;
    logic                           i_stall                = 1'b0;
    logic                           o_relay_on;
    logic                           o_cooling_pause;
    logic                           o_high_level_override;

    relay_tracker tracker = new();

    // Traffic shaping knobs, set per phase by the stimulus.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int send_quiet     = 0;
    int recv_quiet     = 0;
    int hold_left      = 0;
    bit hold_req       = 1'b0;

    // Random-walk levels so the latches and timers see sustained runs.
    int sonar_walk  = 500;
    int analog_walk = 500;

    tank_pump_controller #(
        .TIMER_BITS(TICK_BITS)
    ) u_dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg_we              (i_cfg_we),
        .i_cfg_idx             (i_cfg_idx),
        .i_cfg_data            (i_cfg_data),
        .i_valid               (i_valid),
        .o_stall               (o_stall),
        .i_sonar_level         (i_sonar_level),
        .i_analog_level        (i_analog_level),
        .i_force_switch_changed(i_force_switch_changed),
        .i_force_switch_closed (i_force_switch_closed),
        .i_remote_force_toggle (i_remote_force_toggle),
        .i_auto_switch_closed  (i_auto_switch_closed),
        .o_valid               (o_valid),
        .i_stall               (i_stall),
        .o_relay_on            (o_relay_on),
        .o_cooling_pause       (o_cooling_pause),
        .o_high_level_override (o_high_level_override)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Receiver: random stall, calm stretches, and a long hold-off on request
    // so the block fills up and pushes back on its input.
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_left = 80;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (recv_quiet > 0) begin
            recv_quiet--;
            i_stall <= 1'b0;
        end else begin
            if ($urandom_range(99) == 0)
                recv_quiet = 30;
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Check every result beat the receiver takes.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            tracker.check_relay('{o_relay_on, o_cooling_pause, o_high_level_override});
    end

    function automatic tpc_pkg::t_in_beat make_tick(logic [9:0] s_lvl, logic [9:0] a_lvl,
                                                    bit chg, bit cls, bit tog, bit aut);
        tpc_pkg::t_in_beat b;
        b.sonar_level          = s_lvl;
        b.analog_level         = a_lvl;
        b.force_switch_changed = chg;
        b.force_switch_closed  = cls;
        b.remote_force_toggle  = tog;
        b.auto_switch_closed   = aut;
        return b;
    endfunction

    function automatic int walk_level(int lvl);
        int nxt;
        if ($urandom_range(99) < 3)
            return int'($urandom_range(1023));
        nxt = lvl + int'($urandom_range(80)) - 40;
        if (nxt < 0)
            nxt = 0;
        if (nxt > 1023)
            nxt = 1023;
        return nxt;
    endfunction

    // Mostly slowly moving levels with auto on; a slice of pure noise.
    function automatic tpc_pkg::t_in_beat next_tick();
        if ($urandom_range(99) < 12)
            return make_tick(10'($urandom_range(1023)), 10'($urandom_range(1023)),
                             1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
        sonar_walk  = walk_level(sonar_walk);
        analog_walk = walk_level(analog_walk);
        return make_tick(10'(sonar_walk), 10'(analog_walk),
                         $urandom_range(99) < 4, 1'($urandom),
                         $urandom_range(99) < 3, $urandom_range(99) < 90);
    endfunction

    function automatic t_pump_setting pick_setting(int phase);
        t_pump_setting s;
        s.stop_lvl   = 10'($urandom_range(150, 400));
        s.start_lvl  = 10'($urandom_range(400, 650));
        s.forced_lvl = 10'($urandom_range(700, 980));
        s.max_run    = 16'($urandom_range(1, 40));
        s.pause_len  = 16'($urandom_range(0, 25));
        s.sonar_en   = 1'b1;
        s.analog_en  = 1'b1;
        case (phase)
            0: begin
                s.stop_lvl   = 10'd0;
                s.start_lvl  = 10'd0;
                s.forced_lvl = 10'd1000;
                s.max_run    = 16'd0;
                s.pause_len  = 16'd0;
            end
            2: begin
                s.stop_lvl   = 10'd0;
                s.start_lvl  = 10'd1000;
                s.forced_lvl = 10'd1000;
                s.max_run    = 16'hFFFF;
                s.pause_len  = 16'hFFFF;
            end
            3: s.analog_en = 1'b0;
            4: begin
                s.sonar_en   = 1'b0;
                s.forced_lvl = 10'd1023;
            end
            5: begin
                s.stop_lvl   = 10'd1000;
                s.start_lvl  = 10'd1000;
                s.forced_lvl = 10'd0;
                s.max_run    = 16'd0;
                s.pause_len  = 16'hFFFF;
            end
            7: begin
                s.sonar_en  = 1'b0;
                s.analog_en = 1'b0;
            end
            default: ;
        endcase
        return s;
    endfunction

    // Drive one register write and wait for the clock edge that takes it; the caller drops the write enable.
    task automatic write_reg(tpc_pkg::t_cfg_idx idx, logic [tpc_pkg::CFG_DATA_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        tracker.set_reg(idx, val);
    endtask

    task automatic apply_setting(t_pump_setting s);
        write_reg(tpc_pkg::CFG_STOP_PERCENT, 16'(s.stop_lvl));
        write_reg(tpc_pkg::CFG_START_PERCENT, 16'(s.start_lvl));
        write_reg(tpc_pkg::CFG_FORCED_START_PERCENT, 16'(s.forced_lvl));
        write_reg(tpc_pkg::CFG_MAX_RUN_TICKS, s.max_run);
        write_reg(tpc_pkg::CFG_PAUSE_TICKS, s.pause_len);
        write_reg(tpc_pkg::CFG_SONAR_ENABLE, 16'(s.sonar_en));
        write_reg(tpc_pkg::CFG_ANALOG_ENABLE, 16'(s.analog_en));
        i_cfg_we <= 1'b0;
    endtask

    // Offer one tick; idle first at random, then hold the beat until taken.
    task automatic send_tick(tpc_pkg::t_in_beat b);
        if (send_quiet > 0)
            send_quiet--;
        else if ($urandom_range(199) == 0)
            send_quiet = 40;
        while (send_quiet == 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid                <= 1'b1;
        i_sonar_level          <= b.sonar_level;
        i_analog_level         <= b.analog_level;
        i_force_switch_changed <= b.force_switch_changed;
        i_force_switch_closed  <= b.force_switch_closed;
        i_remote_force_toggle  <= b.remote_force_toggle;
        i_auto_switch_closed   <= b.auto_switch_closed;
        do
            @(posedge i_clk);
        while (o_stall);
        tracker.note_tick(b);
    endtask

    // Stop offering, let every owed result arrive, then allow the pipeline to settle.
    task automatic drain_results();
        i_valid <= 1'b0;
        while (tracker.expected_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Hard stop well past the slowest legal run.
    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int phase_items[8] = '{230, 260, 200, 240, 240, 200, 400, 60};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed ticks under the reset setting; sender and receiver both jittery.
        send_idle_pct  = 37;
        recv_stall_pct = 69;
        send_tick(make_tick(10'd0, 10'd0, 1'b0, 1'b0, 1'b0, 1'b0));
        send_tick(make_tick(10'd0, 10'd0, 1'b1, 1'b1, 1'b0, 1'b0));     // forced, no level
        send_tick(make_tick(10'd600, 10'd600, 1'b0, 1'b0, 1'b0, 1'b0));
        send_tick(make_tick(10'd1000, 10'd1000, 1'b0, 1'b0, 1'b0, 1'b0)); // high override
        send_tick(make_tick(10'd1023, 10'd1023, 1'b0, 1'b0, 1'b0, 1'b0)); // out of range
        send_tick(make_tick(10'd600, 10'd600, 1'b0, 1'b0, 1'b1, 1'b1));  // toggle off, auto
        send_tick(make_tick(10'd400, 10'd400, 1'b0, 1'b0, 1'b0, 1'b1));  // latch holds
        send_tick(make_tick(10'd200, 10'd200, 1'b0, 1'b0, 1'b0, 1'b1));  // below stop
        send_tick(make_tick(10'd300, 10'd300, 1'b1, 1'b0, 1'b1, 1'b0));  // change then toggle
        send_tick(make_tick(10'd300, 10'd300, 1'b1, 1'b1, 1'b1, 1'b0));
        send_tick(make_tick(10'd1000, 10'd0, 1'b0, 1'b0, 1'b0, 1'b1));
        send_tick(make_tick(10'd0, 10'd1000, 1'b0, 1'b0, 1'b0, 1'b1));
        send_tick(make_tick(10'd250, 10'd500, 1'b0, 1'b0, 1'b0, 1'b1)); // on the thresholds
        send_tick(make_tick(10'd501, 10'd249, 1'b0, 1'b0, 1'b0, 1'b1));
        send_tick(make_tick(10'd801, 10'd801, 1'b0, 1'b0, 1'b0, 1'b1));
        send_tick(make_tick(10'd800, 10'd1001, 1'b1, 1'b1, 1'b0, 1'b0));
        send_tick(make_tick(10'd1023, 10'd0, 1'b0, 1'b0, 1'b1, 1'b1));

        for (int phase = 0; phase < 8; phase++) begin
            drain_results();
            apply_setting(pick_setting(phase));
            // Receiver-heavy stalling first, then sender-heavy idling, then none.
            if (phase < 3) begin
                send_idle_pct  = 37;
                recv_stall_pct = 69;
            end else if (phase < 6) begin
                send_idle_pct  = 69;
                recv_stall_pct = 37;
            end else begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            for (int k = 0; k < phase_items[phase]; k++) begin
                if (k == phase_items[phase] / 2) begin
                    if (phase == 1 || phase == 4 || phase == 6)
                        hold_req = 1'b1;
                    if (phase == 2 || phase == 5)
                        drain_results();
                end
                send_tick(next_tick());
            end
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.expected_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/tpc_pkg.sv
rtl/tank_pump_controller.sv
dv/tb_top.sv
